// ----- rtl/qeec_pkg.sv -----
// Shared types, widths, constants and helper functions for the quaternion error corrector.
package qeec_pkg;

  localparam int QW = 32;  // quaternion component width, Q1.30
  localparam int TW = 34;  // multiplier operand width, sine and cosine values
  localparam int ZW = 33;  // CORDIC residual angle width
  localparam int AW = 36;  // angle width during range reduction
  localparam int PW = 2 * TW;  // full product width
  localparam int RW = PW - 30;  // rounded product width
  localparam int SW = RW + 2;  // width of a sum of four rounded terms

  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [TW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [PW-1:0] HALF_LSB    = 68'sd536870912;

  typedef logic [3:0][QW-1:0] quat_t;

  typedef struct packed {
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cp;
    logic signed [TW-1:0] sp;
    logic signed [TW-1:0] cro;
    logic signed [TW-1:0] sro;
  } trig_set_t;

  typedef struct packed {
    logic yaw_nz;
    logic rp_nz;
  } corr_ctl_t;

  // Arctangent of 2^-i in Q.30.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021679;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd31: v = 30'd0;
      default: v = 30'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  // Round a Q.60 product to Q.30: add half an LSB, then floor.
  function automatic logic signed [RW-1:0] rnd30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + HALF_LSB;
    return s[PW-1:30];
  endfunction

endpackage

// ----- rtl/quat_euler_error_correction.sv -----
// Top level of the quaternion attitude corrector by Euler error angles.
// One beat per clock: a new quaternion and error-angle set is taken every cycle while the
// result side is not stalled. Its corrected quaternion passes through one range-reduction
// register, CORDIC_STAGES rotation stages plus a sign-fix register in each of four parallel
// sine/cosine lanes, and six multiply, round and clip stages. The whole pipeline advances
// together and holds while out_tvalid is high and out_tready is low. out_tuser flags that
// a product component was clipped.
module quat_euler_error_correction #(
  parameter int DATA_WIDTH    = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_w, in_x, in_y, in_z, yaw_error, roll_error, pitch_error, roll_angle
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_w, out_x, out_y, out_z
  output logic [127:0] out_tdata,
  // saturated
  output logic [0:0]   out_tuser
);

  localparam int SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int SDLY  = CORDIC_STAGES + 2;
  localparam int LAT   = CORDIC_STAGES + 8;

  typedef struct packed {
    qeec_pkg::quat_t     q;
    qeec_pkg::corr_ctl_t ctl;
  } side_t;

  logic                en;
  logic [LAT-1:0]      vld_r;
  side_t               side_nxt;
  side_t               side_r [SDLY];
  logic signed [qeec_pkg::ZW-1:0] z_r [4];
  logic                           f_r [4];
  logic signed [qeec_pkg::TW-1:0] cos_v [4];
  logic signed [qeec_pkg::TW-1:0] sin_v [4];
  qeec_pkg::trig_set_t trig;
  qeec_pkg::quat_t     res;
  logic                sat;

  assign en        = !out_tvalid || out_tready;
  // No beat is taken while the valid chain is held in reset.
  assign in_tready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_comb begin
    side_nxt.q          = in_tdata[127:0];
    side_nxt.ctl.yaw_nz = |in_tdata[159:128];
    side_nxt.ctl.rp_nz  = (|in_tdata[191:160]) || (|in_tdata[223:192]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < SDLY; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Lanes: yaw error, roll error, pitch error (half angles), roll angle (full angle).
  for (genvar l = 0; l < 4; l++) begin : g_lane
    qeec_prep #(.SHIFT((l == 3) ? 2 : 1)) u_prep (
      .clk    (clk),
      .en     (en),
      .angle  ($signed(in_tdata[128+32*l +: 32])),
      .z_r    (z_r[l]),
      .flip_r (f_r[l])
    );

    qeec_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clk     (clk),
      .en      (en),
      .z_in    (z_r[l]),
      .flip_in (f_r[l]),
      .c_r     (cos_v[l]),
      .s_r     (sin_v[l])
    );
  end

  always_comb begin
    trig.cy  = cos_v[0];
    trig.sy  = sin_v[0];
    trig.cr  = cos_v[1];
    trig.sr  = sin_v[1];
    trig.cp  = cos_v[2];
    trig.sp  = sin_v[2];
    trig.cro = cos_v[3];
    trig.sro = sin_v[3];
  end

  qeec_qmath #(.SAT_W(SAT_W)) u_qmath (
    .clk   (clk),
    .en    (en),
    .trig  (trig),
    .q     (side_r[SDLY-1].q),
    .ctl   (side_r[SDLY-1].ctl),
    .res_r (res),
    .sat_r (sat)
  );

  assign out_tvalid   = vld_r[LAT-1];
  assign out_tdata    = res;
  assign out_tuser[0] = sat;

  // A stalled pipeline must keep every item in flight where it is.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid chain moved during a stall");

  // An accepted beat must enter the first pipeline stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted beat lost at pipeline entry");

endmodule

// ----- rtl/qeec_prep.sv -----
// Angle scaling, negation and range reduction ahead of one CORDIC lane.
module qeec_prep #(
  parameter int SHIFT = 1
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [31:0]               angle,
  output logic signed [qeec_pkg::ZW-1:0]   z_r,
  output logic                             flip_r
);

  logic signed [qeec_pkg::AW-1:0] ext;
  logic signed [qeec_pkg::AW-1:0] neg;
  logic signed [qeec_pkg::AW-1:0] wrap;
  logic signed [qeec_pkg::AW-1:0] fold;
  logic signed [qeec_pkg::ZW-1:0] z_nxt;
  logic                           flip_nxt;

  always_comb begin
    ext  = {{(qeec_pkg::AW-32){angle[31]}}, angle};
    neg  = -(ext <<< SHIFT);
    // One step of 2*pi is enough for the widest scaled input.
    if (neg > qeec_pkg::PI_Q30) begin
      wrap = neg - qeec_pkg::TWO_PI_Q30;
    end else if (neg < -qeec_pkg::PI_Q30) begin
      wrap = neg + qeec_pkg::TWO_PI_Q30;
    end else begin
      wrap = neg;
    end
    flip_nxt = 1'b1;
    if (wrap > qeec_pkg::HALF_PI_Q30) begin
      fold = wrap - qeec_pkg::PI_Q30;
    end else if (wrap < -qeec_pkg::HALF_PI_Q30) begin
      fold = wrap + qeec_pkg::PI_Q30;
    end else begin
      fold     = wrap;
      flip_nxt = 1'b0;
    end
    z_nxt = fold[qeec_pkg::ZW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r    <= z_nxt;
      flip_r <= flip_nxt;
    end
  end

endmodule

// ----- rtl/qeec_cordic.sv -----
// Pipelined rotation-mode CORDIC, one stage register per iteration.
module qeec_cordic #(
  parameter int STAGES = 24
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [qeec_pkg::ZW-1:0] z_in,
  input  logic                           flip_in,
  output logic signed [qeec_pkg::TW-1:0] c_r,
  output logic signed [qeec_pkg::TW-1:0] s_r
);

  logic signed [qeec_pkg::TW-1:0] x_r [STAGES];
  logic signed [qeec_pkg::TW-1:0] y_r [STAGES];
  logic signed [qeec_pkg::ZW-1:0] z_r [STAGES-1];
  logic                           f_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [qeec_pkg::TW-1:0] xi;
    logic signed [qeec_pkg::TW-1:0] yi;
    logic signed [qeec_pkg::ZW-1:0] zi;
    logic                           fi;
    logic signed [qeec_pkg::ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign xi = qeec_pkg::GAIN_Q30;
      assign yi = '0;
      assign zi = z_in;
      assign fi = flip_in;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = f_r[i-1];
    end

    assign ang = $signed({3'b000, qeec_pkg::atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i] <= fi;
        if (!zi[qeec_pkg::ZW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
        end
      end
    end

    if (i < STAGES - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i] <= zi[qeec_pkg::ZW-1] ? zi + ang : zi - ang;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= f_r[STAGES-1] ? -x_r[STAGES-1] : x_r[STAGES-1];
      s_r <= f_r[STAGES-1] ? -y_r[STAGES-1] : y_r[STAGES-1];
    end
  end

endmodule

// ----- rtl/qeec_qmath.sv -----
// Six-stage multiply, round, sum and clip pipeline for the three quaternion products.
module qeec_qmath #(
  parameter int SAT_W = 32
) (
  input  logic                        clk,
  input  logic                        en,
  input  qeec_pkg::trig_set_t         trig,
  input  qeec_pkg::quat_t             q,
  input  qeec_pkg::corr_ctl_t         ctl,
  output qeec_pkg::quat_t             res_r,
  output logic                        sat_r
);

  localparam logic signed [qeec_pkg::SW-1:0] HI =
    (qeec_pkg::SW'(1) <<< (SAT_W - 1)) - qeec_pkg::SW'(1);
  localparam logic signed [qeec_pkg::SW-1:0] LO = -HI - qeec_pkg::SW'(1);

  // Returns the clip flag above the clipped Q1.30 value.
  function automatic logic [qeec_pkg::QW:0] clip(input logic signed [qeec_pkg::SW-1:0] v);
    logic [qeec_pkg::QW:0] o;
    if (v > HI) begin
      o = {1'b1, HI[qeec_pkg::QW-1:0]};
    end else if (v < LO) begin
      o = {1'b1, LO[qeec_pkg::QW-1:0]};
    end else begin
      o = {1'b0, v[qeec_pkg::QW-1:0]};
    end
    return o;
  endfunction

  function automatic logic signed [qeec_pkg::PW-1:0] mul(
    input logic signed [qeec_pkg::TW-1:0] a,
    input logic signed [qeec_pkg::TW-1:0] b
  );
    return qeec_pkg::PW'(a) * qeec_pkg::PW'(b);
  endfunction

  function automatic logic signed [qeec_pkg::TW-1:0] ext(input logic [qeec_pkg::QW-1:0] v);
    return qeec_pkg::TW'($signed(v));
  endfunction

  function automatic logic signed [qeec_pkg::SW-1:0] rs(input logic signed [qeec_pkg::PW-1:0] p);
    return qeec_pkg::SW'(qeec_pkg::rnd30(p));
  endfunction

  // Stage 1: yaw rotation products and the pitch-axis products.
  logic signed [qeec_pkg::PW-1:0] p1_r [8];
  logic signed [qeec_pkg::PW-1:0] pp1_r [2];
  qeec_pkg::quat_t                q1_r;
  logic signed [qeec_pkg::TW-1:0] cr1_r, sr1_r, cp1_r;
  qeec_pkg::corr_ctl_t            ctl1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= mul(trig.cy, ext(q[0]));
      p1_r[1] <= mul(trig.sy, ext(q[3]));
      p1_r[2] <= mul(trig.cy, ext(q[1]));
      p1_r[3] <= mul(trig.sy, ext(q[2]));
      p1_r[4] <= mul(trig.cy, ext(q[2]));
      p1_r[5] <= mul(trig.sy, ext(q[1]));
      p1_r[6] <= mul(trig.cy, ext(q[3]));
      p1_r[7] <= mul(trig.sy, ext(q[0]));
      pp1_r[0] <= mul(trig.sp, trig.cro);
      pp1_r[1] <= mul(trig.sp, trig.sro);
      q1_r   <= q;
      cr1_r  <= trig.cr;
      sr1_r  <= trig.sr;
      cp1_r  <= trig.cp;
      ctl1_r <= ctl;
    end
  end

  // Stage 2: yaw product sums and clip, pitch axis terms rounded.
  qeec_pkg::quat_t                res2_nxt, res2_r;
  logic                           sat2_nxt, sat2_r;
  logic signed [qeec_pkg::TW-1:0] p2_nxt, p3_nxt, p2_r, p3_r;
  logic signed [qeec_pkg::TW-1:0] cr2_r, sr2_r, cp2_r;
  qeec_pkg::corr_ctl_t            ctl2_r;
  logic signed [qeec_pkg::SW-1:0] t2 [4];
  logic [qeec_pkg::QW:0]          c2 [4];
  logic signed [qeec_pkg::RW-1:0] r3_tmp;

  always_comb begin
    t2[0] = rs(p1_r[0]) - rs(p1_r[1]);
    t2[1] = rs(p1_r[2]) - rs(p1_r[3]);
    t2[2] = rs(p1_r[4]) + rs(p1_r[5]);
    t2[3] = rs(p1_r[6]) + rs(p1_r[7]);
    sat2_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      c2[k]    = clip(t2[k]);
      sat2_nxt = sat2_nxt | (ctl1_r.yaw_nz & c2[k][qeec_pkg::QW]);
      res2_nxt[k] = ctl1_r.yaw_nz ? c2[k][qeec_pkg::QW-1:0] : q1_r[k];
    end
    p2_nxt = qeec_pkg::TW'(qeec_pkg::rnd30(pp1_r[0]));
    r3_tmp = qeec_pkg::rnd30(pp1_r[1]);
    p3_nxt = -qeec_pkg::TW'(r3_tmp);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res2_r <= res2_nxt;
      sat2_r <= sat2_nxt;
      p2_r   <= p2_nxt;
      p3_r   <= p3_nxt;
      cr2_r  <= cr1_r;
      sr2_r  <= sr1_r;
      cp2_r  <= cp1_r;
      ctl2_r <= ctl1_r;
    end
  end

  // Stage 3: products of the pitch and roll-error rotations.
  logic signed [qeec_pkg::PW-1:0] m3_r [6];
  qeec_pkg::quat_t                res3_r;
  logic                           sat3_r;
  qeec_pkg::corr_ctl_t            ctl3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r[0] <= mul(cp2_r, cr2_r);
      m3_r[1] <= mul(cp2_r, sr2_r);
      m3_r[2] <= mul(p2_r, cr2_r);
      m3_r[3] <= mul(p3_r, sr2_r);
      m3_r[4] <= mul(p2_r, sr2_r);
      m3_r[5] <= mul(p3_r, cr2_r);
      res3_r  <= res2_r;
      sat3_r  <= sat2_r;
      ctl3_r  <= ctl2_r;
    end
  end

  // Stage 4: combined correction rotation summed and clipped.
  qeec_pkg::quat_t                pr4_nxt, pr4_r, res4_r;
  logic                           sat4_nxt, sat4_r;
  qeec_pkg::corr_ctl_t            ctl4_r;
  logic signed [qeec_pkg::SW-1:0] t4 [4];
  logic [qeec_pkg::QW:0]          c4 [4];

  always_comb begin
    t4[0] = rs(m3_r[0]);
    t4[1] = rs(m3_r[1]);
    t4[2] = rs(m3_r[2]) + rs(m3_r[3]);
    t4[3] = rs(m3_r[5]) - rs(m3_r[4]);
    sat4_nxt = sat3_r;
    for (int k = 0; k < 4; k++) begin
      c4[k]      = clip(t4[k]);
      sat4_nxt   = sat4_nxt | (ctl3_r.rp_nz & c4[k][qeec_pkg::QW]);
      pr4_nxt[k] = c4[k][qeec_pkg::QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr4_r  <= pr4_nxt;
      res4_r <= res3_r;
      sat4_r <= sat4_nxt;
      ctl4_r <= ctl3_r;
    end
  end

  // Stage 5: all sixteen products of the final Hamilton product.
  logic signed [qeec_pkg::PW-1:0] m5_r [16];
  qeec_pkg::quat_t                res5_r;
  logic                           sat5_r;
  qeec_pkg::corr_ctl_t            ctl5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          m5_r[i*4+j] <= mul(ext(res4_r[i]), ext(pr4_r[j]));
        end
      end
      res5_r <= res4_r;
      sat5_r <= sat4_r;
      ctl5_r <= ctl4_r;
    end
  end

  // Stage 6: final sums, clip and output register.
  qeec_pkg::quat_t                res_nxt;
  logic                           sat_nxt;
  logic signed [qeec_pkg::SW-1:0] t6 [4];
  logic [qeec_pkg::QW:0]          c6 [4];

  always_comb begin
    t6[0] = rs(m5_r[0]) - rs(m5_r[5]) - rs(m5_r[10]) - rs(m5_r[15]);
    t6[1] = rs(m5_r[1]) + rs(m5_r[4]) + rs(m5_r[11]) - rs(m5_r[14]);
    t6[2] = rs(m5_r[2]) - rs(m5_r[7]) + rs(m5_r[8]) + rs(m5_r[13]);
    t6[3] = rs(m5_r[3]) + rs(m5_r[6]) - rs(m5_r[9]) + rs(m5_r[12]);
    sat_nxt = sat5_r;
    for (int k = 0; k < 4; k++) begin
      c6[k]      = clip(t6[k]);
      sat_nxt    = sat_nxt | (ctl5_r.rp_nz & c6[k][qeec_pkg::QW]);
      res_nxt[k] = ctl5_r.rp_nz ? c6[k][qeec_pkg::QW-1:0] : res5_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the quaternion Euler-error corrector.
module tb_top;

  localparam int DW = 32;
  localparam int NST = 24;
  localparam int LAT = NST + 8;
  localparam longint PI_V = 64'sd3373259426;
  localparam longint TWO_PI_V = 64'sd6746518852;
  localparam longint HALF_PI_V = 64'sd1686629713;
  localparam longint GAIN_V = 64'sd652032874;
  localparam int NRAND = 1200;
  localparam int NDIR = 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] w, x, y, z, yaw, rerr, perr, roll;
  } corr_in_t;

  typedef struct {
    logic [31:0] w, x, y, z;
    logic sat;
  } corr_out_t;

  // Directed row: stimulus plus, where known, the expected quaternion.
  typedef struct {
    corr_in_t stim;
    bit known;
    corr_out_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [255:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [0:0] out_tuser;

  corr_out_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int src_idle = 0;
  int snk_idle = 0;

  quat_euler_error_correction #(.DATA_WIDTH(DW), .CORDIC_STAGES(NST)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint atan_val(int i);
    longint tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021679,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2, 1, 0};
    return tab[i];
  endfunction

  function automatic void cordic_sincos(longint ang, output longint c, output longint s);
    longint cx, sy, dx, dy;
    bit flip;
    cx = GAIN_V;
    sy = 0;
    flip = 0;
    while (ang > PI_V) ang -= TWO_PI_V;
    while (ang < -PI_V) ang += TWO_PI_V;
    if (ang > HALF_PI_V) begin
      ang -= PI_V;
      flip = 1;
    end else if (ang < -HALF_PI_V) begin
      ang += PI_V;
      flip = 1;
    end
    for (int i = 0; i < NST; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx -= dx; sy += dy; ang -= atan_val(i);
      end else begin
        cx += dx; sy -= dy; ang += atan_val(i);
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -sy : sy;
  endfunction

  // Products fit in 64 bits: operands are at most 2^31 in magnitude.
  function automatic longint mul_round(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint clamp(longint v, ref bit flag);
    longint hi, lo;
    hi = (64'sd1 <<< ((DW < 32 ? DW : 32) - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin flag = 1; return hi; end
    if (v < lo) begin flag = 1; return lo; end
    return v;
  endfunction

  function automatic void hamilton(longint l[4], longint r[4], output longint o[4],
                                   ref bit flag);
    longint t[4];
    t[0] = mul_round(l[0], r[0]) - mul_round(l[1], r[1]) - mul_round(l[2], r[2])
         - mul_round(l[3], r[3]);
    t[1] = mul_round(l[0], r[1]) + mul_round(l[1], r[0]) + mul_round(l[2], r[3])
         - mul_round(l[3], r[2]);
    t[2] = mul_round(l[0], r[2]) - mul_round(l[1], r[3]) + mul_round(l[2], r[0])
         + mul_round(l[3], r[1]);
    t[3] = mul_round(l[0], r[3]) + mul_round(l[1], r[2]) - mul_round(l[2], r[1])
         + mul_round(l[3], r[0]);
    for (int k = 0; k < 4; k++) o[k] = clamp(t[k], flag);
  endfunction

  function automatic corr_out_t predict_correction(corr_in_t s);
    longint q[4], acc[4], e[4], p[4], pr[4];
    longint yaw, rerr, perr, roll, c, sn, cr, sr, cp, sp, cro, sro;
    bit flag;
    corr_out_t r;
    flag = 0;
    q[0] = longint'($signed(s.w)); q[1] = longint'($signed(s.x));
    q[2] = longint'($signed(s.y)); q[3] = longint'($signed(s.z));
    yaw = longint'($signed(s.yaw)); rerr = longint'($signed(s.rerr));
    perr = longint'($signed(s.perr)); roll = longint'($signed(s.roll));
    acc = q;
    if (yaw != 0) begin
      cordic_sincos(-yaw * 2, c, sn);
      e = '{c, 0, 0, sn};
      hamilton(e, q, acc, flag);
    end
    if (rerr != 0 || perr != 0) begin
      cordic_sincos(-rerr * 2, cr, sr);
      cordic_sincos(-perr * 2, cp, sp);
      cordic_sincos(-roll * 4, cro, sro);
      e = '{cr, sr, 0, 0};
      p = '{cp, 0, mul_round(sp, cro), -mul_round(sp, sro)};
      hamilton(p, e, pr, flag);
      q = acc;
      hamilton(q, pr, acc, flag);
    end
    r.w = acc[0][31:0]; r.x = acc[1][31:0]; r.y = acc[2][31:0]; r.z = acc[3][31:0];
    r.sat = flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Result side: random stalls and comparison against the oldest expectation.
  always @(posedge clk) begin
    corr_out_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", out_tdata[31:0], 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[31:0] !== want.w) report_mismatch("w", out_tdata[31:0], want.w);
          if (out_tdata[63:32] !== want.x) report_mismatch("x", out_tdata[63:32], want.x);
          if (out_tdata[95:64] !== want.y) report_mismatch("y", out_tdata[95:64], want.y);
          if (out_tdata[127:96] !== want.z) report_mismatch("z", out_tdata[127:96], want.z);
          if (out_tuser[0] !== want.sat) begin
            report_mismatch("saturated", {31'b0, out_tuser[0]}, {31'b0, want.sat});
          end
        end
      end
      out_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return $urandom();
      2: return 32'($signed($urandom_range(1686629713)) - 843314857);
      default: return 32'($signed($urandom_range(200000000)) - 100000000);
    endcase
  endfunction

  function automatic logic [31:0] rand_comp();
    if ($urandom_range(9) == 0) return $urandom();
    return 32'($signed($urandom_range(2147483647)) - 1073741823);
  endfunction

  task automatic send_beat(corr_in_t s);
    in_tdata <= {s.roll, s.perr, s.rerr, s.yaw, s.z, s.y, s.x, s.w};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_checked(corr_in_t s, bit known, corr_out_t res);
    corr_out_t p;
    p = predict_correction(s);
    expected_q.push_back(known ? res : p);
    send_beat(s);
  endtask

  initial begin
    dir_row_t rows[NDIR];
    corr_in_t s;
    corr_out_t none;
    none = '{default: '0};
    rows[0] = '{'{32'h40000000, 0, 0, 0, 0, 0, 0, 0}, 1, '{32'h40000000, 0, 0, 0, 0}};
    rows[1] = '{'{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0,
                  32'h7fffffff}, 1, '{32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 0}};
    rows[2] = '{'{32'h40000000, 0, 0, 0, 32'h10000000, 0, 0, 0}, 0, none};
    rows[3] = '{'{32'h40000000, 0, 0, 0, 0, 32'h10000000, 0, 0}, 0, none};
    rows[4] = '{'{32'h40000000, 0, 0, 0, 0, 0, 32'h10000000, 32'h08000000}, 0, none};
    rows[5] = '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 0, none};
    rows[6] = '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h80000000}, 0, none};
    rows[7] = '{'{32'h2d413ccd, 32'h2d413ccd, 0, 0, 32'hf0000000, 32'hf8000000,
                  32'h04000000, 32'hd0000000}, 0, none};
    rows[8] = '{'{32'h40000000, 0, 0, 0, 32'h3243f6a9, 0, 0, 0}, 0, none};
    rows[9] = '{'{0, 32'h40000000, 0, 0, 0, 32'h1921fb54, 32'he6de04ac, 32'h3243f6a9},
                0, none};
    rows[10] = '{'{32'h20000000, 32'h20000000, 32'h20000000, 32'h20000000, 1, 1, 1, 1},
                 0, none};
    rows[11] = '{'{32'hffffffff, 1, 32'hffffffff, 1, 32'hffffffff, 0, 32'hffffffff,
                   32'h80000000}, 0, none};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_idle = 11;
    snk_idle = 56;
    foreach (rows[i]) send_checked(rows[i].stim, rows[i].known, rows[i].res);
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 11 : (ph == 1) ? 56 : 0;
      snk_idle = (ph == 0) ? 56 : (ph == 1) ? 11 : 0;
      for (int n = 0; n < NRAND / 3; n++) begin
        s.w = rand_comp(); s.x = rand_comp(); s.y = rand_comp(); s.z = rand_comp();
        s.yaw = rand_angle(); s.rerr = rand_angle(); s.perr = rand_angle();
        s.roll = ($urandom_range(3) == 0) ? $urandom() : rand_angle();
        send_checked(s, 0, none);
      end
    end
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
